### src/wbps_pkg.sv
// shared constants and types for the wildcard byte pattern scan
package wbps_pkg;

    localparam int MAX_PATTERN    = 32;
    localparam int OFFSET_BITS    = 32;
    localparam int ADDR_BITS      = 64;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int LEN_BITS       = 6;
    localparam int PATTERN_WORDS  = 4;
    localparam int PATTERN_BYTES  = PATTERN_WORDS * 8;
    localparam int WINDOW_DEPTH   = MAX_PATTERN - 1;
    localparam int IDX_BITS       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] WILDCARD = 8'h3F;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BASE_ADDRESS   = 3'd0,
        REG_PATTERN_LENGTH = 3'd1,
        REG_PATTERN_0      = 3'd2,
        REG_PATTERN_1      = 3'd3,
        REG_PATTERN_2      = 3'd4,
        REG_PATTERN_3      = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]                        base_address;
        logic [LEN_BITS-1:0]                         pattern_length;
        logic [PATTERN_WORDS-1:0][CFG_DATA_BITS-1:0] pattern_words;
    } cfg_t;

    // one region result as classified by the front end
    typedef struct packed {
        logic                   found;
        logic [OFFSET_BITS-1:0] start_offset;
    } scan_event_t;

endpackage

### src/wbps_if.sv
// stream interfaces for input bytes and scan results

interface wbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte, output last_byte,
                    input ready);
    modport sink (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface wbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink (input valid, input found, input match_address, output ready);
endinterface

### src/wbps_cfg_regs.sv
// configuration register file
module wbps_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [wbps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output wbps_pkg::cfg_t                      cfg
);

    wbps_pkg::cfg_t cfg_reg;
    wbps_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                wbps_pkg::REG_BASE_ADDRESS:   cfg_next.base_address = cfg_data;
                wbps_pkg::REG_PATTERN_LENGTH:
                    cfg_next.pattern_length = cfg_data[wbps_pkg::LEN_BITS-1:0];
                wbps_pkg::REG_PATTERN_0:      cfg_next.pattern_words[0] = cfg_data;
                wbps_pkg::REG_PATTERN_1:      cfg_next.pattern_words[1] = cfg_data;
                wbps_pkg::REG_PATTERN_2:      cfg_next.pattern_words[2] = cfg_data;
                wbps_pkg::REG_PATTERN_3:      cfg_next.pattern_words[3] = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/wbps_front.sv
// front end: byte window, offset tracking and parallel pattern compare
module wbps_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    wbps_in_if.sink                     in_ch,
    input  wbps_pkg::cfg_t              cfg,
    input  logic                        queue_full,
    output logic                        push,
    output wbps_pkg::scan_event_t       push_event
);

    logic [wbps_pkg::WINDOW_DEPTH-1:0][7:0]  window_reg;
    logic [wbps_pkg::WINDOW_DEPTH-1:0][7:0]  window_next;
    logic [wbps_pkg::OFFSET_BITS-1:0]        offset_reg;
    logic [wbps_pkg::OFFSET_BITS-1:0]        offset_next;
    logic                                    done_reg;
    logic                                    done_next;

    logic                                    accept;
    logic [wbps_pkg::OFFSET_BITS-1:0]        pos;
    logic                                    done_now;
    logic [wbps_pkg::MAX_PATTERN-1:0][7:0]   recent;
    logic [wbps_pkg::PATTERN_BYTES*8-1:0]    pattern_flat;
    logic [wbps_pkg::MAX_PATTERN-1:0]        byte_ok;
    logic [wbps_pkg::LEN_BITS:0]             len_ext;
    logic                                    len_ok;
    logic                                    pos_ok;
    logic                                    match;
    logic [7:0]                              pat_byte;
    logic [wbps_pkg::LEN_BITS:0]             back_full;
    logic [wbps_pkg::IDX_BITS-1:0]           back_idx;

    assign in_ch.ready  = !queue_full;
    assign accept       = in_ch.valid && in_ch.ready;
    assign pattern_flat = cfg.pattern_words;
    assign len_ext      = {1'b0, cfg.pattern_length};

    assign pos      = in_ch.first_byte ? '0 : offset_reg;
    assign done_now = in_ch.first_byte ? 1'b0 : done_reg;

    always_comb
    begin
        recent[0] = in_ch.data_byte;
        for (int k = 1; k < wbps_pkg::MAX_PATTERN; k++)
        begin
            recent[k] = window_reg[k-1];
        end
    end

    // pattern byte j lines up with the byte len-1-j places back
    always_comb
    begin
        pat_byte  = '0;
        back_full = '0;
        back_idx  = '0;
        for (int j = 0; j < wbps_pkg::MAX_PATTERN; j++)
        begin
            if (j < wbps_pkg::PATTERN_BYTES)
            begin
                pat_byte = pattern_flat[(j & (wbps_pkg::PATTERN_BYTES - 1)) * 8 +: 8];
            end
            else
            begin
                pat_byte = '0;
            end
            back_full = len_ext - (wbps_pkg::LEN_BITS + 1)'(j) - (wbps_pkg::LEN_BITS + 1)'(1);
            back_idx  = back_full[wbps_pkg::IDX_BITS-1:0];
            byte_ok[j] = (len_ext <= (wbps_pkg::LEN_BITS + 1)'(j)) ||
                         (pat_byte == wbps_pkg::WILDCARD) ||
                         (pat_byte == recent[back_idx]);
        end
    end

    assign len_ok = (cfg.pattern_length != '0) &&
                    (len_ext <= (wbps_pkg::LEN_BITS + 1)'(wbps_pkg::MAX_PATTERN));
    assign pos_ok = pos >= (wbps_pkg::OFFSET_BITS'(cfg.pattern_length) - 1'b1);
    assign match  = len_ok && pos_ok && (&byte_ok);

    assign push = accept && !done_now && (match || in_ch.last_byte);
    assign push_event.found = match;
    assign push_event.start_offset = match ?
        (pos - wbps_pkg::OFFSET_BITS'(cfg.pattern_length) + 1'b1) : '0;

    always_comb
    begin
        window_next = window_reg;
        offset_next = offset_reg;
        done_next   = done_reg;
        if (accept)
        begin
            window_next[0] = in_ch.data_byte;
            for (int k = 1; k < wbps_pkg::WINDOW_DEPTH; k++)
            begin
                window_next[k] = window_reg[k-1];
            end
            offset_next = (&pos) ? pos : pos + 1'b1;
            done_next   = done_now || push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            offset_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            offset_reg <= offset_next;
            done_reg   <= done_next;
        end
    end

endmodule

### src/wbps_queue.sv
// short queue of region results between front and back end
module wbps_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  wbps_pkg::scan_event_t push_event,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output wbps_pkg::scan_event_t pop_event
);

    localparam int PTR_BITS = (wbps_pkg::QUEUE_DEPTH > 1) ? $clog2(wbps_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(wbps_pkg::QUEUE_DEPTH + 1);

    wbps_pkg::scan_event_t          slots_reg [wbps_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]            wr_ptr_reg;
    logic [PTR_BITS-1:0]            wr_ptr_next;
    logic [PTR_BITS-1:0]            rd_ptr_reg;
    logic [PTR_BITS-1:0]            rd_ptr_next;
    logic [CNT_BITS-1:0]            count_reg;
    logic [CNT_BITS-1:0]            count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full      = count_reg == CNT_BITS'(wbps_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_event = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(wbps_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(wbps_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_event;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/wbps_back.sv
// back end: address add and registered result output
module wbps_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  wbps_pkg::cfg_t        cfg,
    input  logic                  not_empty,
    input  wbps_pkg::scan_event_t pop_event,
    output logic                  pop,
    wbps_out_if.source            out_ch
);

    logic                            valid_reg;
    logic                            valid_next;
    logic                            found_reg;
    logic                            found_next;
    logic [wbps_pkg::ADDR_BITS-1:0]  addr_reg;
    logic [wbps_pkg::ADDR_BITS-1:0]  addr_next;

    // the output register takes a new transaction when empty or being drained
    assign pop = not_empty && (!valid_reg || out_ch.ready);

    always_comb
    begin
        valid_next = valid_reg;
        found_next = found_reg;
        addr_next  = addr_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            found_next = pop_event.found;
            addr_next  = pop_event.found ?
                (cfg.base_address + wbps_pkg::ADDR_BITS'(pop_event.start_offset)) : '0;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        addr_reg  <= addr_next;
    end

    assign out_ch.valid         = valid_reg;
    assign out_ch.found         = found_reg;
    assign out_ch.match_address = addr_reg;

endmodule

### src/wildcard_byte_pattern_scan_top.sv
// Wildcard byte pattern scan: takes one byte of a memory region per clock, unless the
// queue is full, and reports the first position where the configured pattern (up to 32
// bytes, 0x3F matching any byte) occurs, as base address plus start offset, or not-found
// with address 0 on the region's last byte. One transaction per region; first_byte
// restarts the offset. The window shift and the full parallel pattern compare finish in
// the accepting cycle; the result is written into a two-entry queue, then passes the
// 64-bit address add into the output register.
// Input stalls only when the queue is full because the output side is not taking results.
module wildcard_byte_pattern_scan_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    wbps_in_if.sink                             in_ch,
    wbps_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [wbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [wbps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    wbps_pkg::cfg_t        cfg;
    logic                  push;
    wbps_pkg::scan_event_t push_event;
    logic                  queue_full;
    logic                  pop;
    logic                  not_empty;
    wbps_pkg::scan_event_t pop_event;

    wbps_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wbps_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_event (push_event)
    );

    wbps_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (not_empty),
        .pop_event  (pop_event)
    );

    wbps_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .not_empty (not_empty),
        .pop_event (pop_event),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule

### dv/wbps_scan_checker.sv
// checker for the wildcard byte pattern scan: predicts each region result and compares it
`timescale 1ns / 1ps

module wbps_scan_checker
    import wbps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    wbps_in_if                        in_mon,
    wbps_out_if                       out_mon,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        fail_count,
    output int                        pending_results
);

    typedef struct packed {
        logic                 found;
        logic [ADDR_BITS-1:0] match_address;
    } region_result_t;

    region_result_t region_outcomes[$];

    logic [ADDR_BITS-1:0]                        base_address;
    logic [LEN_BITS-1:0]                         pattern_length;
    logic [PATTERN_WORDS-1:0][CFG_DATA_BITS-1:0] pattern_words;
    logic [7:0]                                  recent[WINDOW_DEPTH];
    logic [OFFSET_BITS-1:0]                      next_offset;
    logic                                        region_closed;
    int                                          mismatches;

    function automatic logic [7:0] pattern_byte(int j);
        if (j >= PATTERN_BYTES)
            return 8'h00;
        return pattern_words[j / 8][(j % 8) * 8 +: 8];
    endfunction

    // recent[0] is the byte just before the current one
    function automatic logic pattern_ends_at(logic [7:0] cur, logic [OFFSET_BITS-1:0] pos);
        int         len;
        int         back;
        logic [7:0] seen;
        logic [7:0] want;
        len = int'(pattern_length);
        if (len == 0 || len > MAX_PATTERN)
            return 1'b0;
        if (longint'(pos) < longint'(len - 1))
            return 1'b0;
        for (int j = 0; j < len; j++)
        begin
            want = pattern_byte(j);
            back = len - 1 - j;
            if (back == 0)
                seen = cur;
            else if (back - 1 < WINDOW_DEPTH)
                seen = recent[back - 1];
            else
                seen = 8'h00;
            if (want != WILDCARD && want != seen)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic advance_scan(logic [7:0] cur, logic first_flag, logic last_flag);
        logic [OFFSET_BITS-1:0] pos;
        region_result_t         outcome;
        if (first_flag)
        begin
            next_offset   = '0;
            region_closed = 1'b0;
        end
        pos = next_offset;
        if (!region_closed)
        begin
            if (pattern_ends_at(cur, pos))
            begin
                outcome.found         = 1'b1;
                outcome.match_address = base_address + ADDR_BITS'(pos) + 64'd1
                                        - ADDR_BITS'(pattern_length);
                region_outcomes = {region_outcomes, outcome};
                region_closed = 1'b1;
            end
            else if (last_flag)
            begin
                outcome.found         = 1'b0;
                outcome.match_address = '0;
                region_outcomes = {region_outcomes, outcome};
                region_closed = 1'b1;
            end
        end
        for (int k = WINDOW_DEPTH - 1; k > 0; k--)
            recent[k] = recent[k - 1];
        recent[0] = cur;
        // offset saturates at all ones
        if (pos != '1)
            next_offset = pos + 1'b1;
    endtask

    task automatic check_result(logic found, logic [ADDR_BITS-1:0] match_address);
        region_result_t want;
        if (region_outcomes.size() == 0)
        begin
            $error("unexpected result transaction: found=%0b match_address=%h",
                   found, match_address);
            mismatches++;
        end
        else
        begin
            want = region_outcomes.pop_front();
            if (found !== want.found)
            begin
                $error("found: expected %0b, actual %0b", want.found, found);
                mismatches++;
            end
            if (match_address !== want.match_address)
            begin
                $error("match_address: expected %h, actual %h",
                       want.match_address, match_address);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address   = '0;
            pattern_length = '0;
            pattern_words  = '0;
            foreach (recent[k])
                recent[k] = 8'h00;
            next_offset   = '0;
            region_closed = 1'b0;
            region_outcomes.delete();
            mismatches = 0;
            fail_count      <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
                check_result(out_mon.found, out_mon.match_address);
            if (in_mon.valid && in_mon.ready)
                advance_scan(in_mon.data_byte, in_mon.first_byte, in_mon.last_byte);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE_ADDRESS:   base_address     = cfg_data;
                    REG_PATTERN_LENGTH: pattern_length   = cfg_data[LEN_BITS-1:0];
                    REG_PATTERN_0:      pattern_words[0] = cfg_data;
                    REG_PATTERN_1:      pattern_words[1] = cfg_data;
                    REG_PATTERN_2:      pattern_words[2] = cfg_data;
                    REG_PATTERN_3:      pattern_words[3] = cfg_data;
                    default: ;
                endcase
            end
            fail_count      <= mismatches;
            pending_results <= region_outcomes.size();
        end
    end

endmodule

### dv/tb_wildcard_byte_pattern_scan_top.sv
// testbench top for the wildcard byte pattern scan: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scan_top;
    import wbps_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int IDLE_PCT      = 17;
    localparam int RANDOM_BYTES  = 1300;
    localparam int RANDOM_PHASES = 12;

    // indexes past the register list, written to make sure they are ignored
    localparam logic [CFG_INDEX_BITS-1:0] UNMAPPED_INDEX_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] UNMAPPED_INDEX_HI = 3'd7;

    typedef enum int {
        REGION_CLEAN,
        REGION_NO_START,
        REGION_NO_END,
        REGION_SCRAMBLED
    } region_shape_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS,
        FILL_WILDCARD
    } signature_fill_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int                        fail_count;
    int                        pending_results;
    int                        in_idle_pct;
    int                        out_idle_pct;
    int                        cycles = 0;

    logic [7:0]           signature[PATTERN_BYTES];
    logic [LEN_BITS-1:0]  signature_len;
    logic [ADDR_BITS-1:0] region_base;

    int            phase;
    int            sent;
    int            span;
    int            roll;
    region_shape_t shape;

    wbps_in_if  in_ch();
    wbps_out_if out_ch();

    wildcard_byte_pattern_scan_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wbps_scan_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_mon          (in_ch),
        .out_mon         (out_ch),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_wildcard_byte_pattern_scan_top NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_signature();
        logic [CFG_DATA_BITS-1:0] word;
        // upper bits of the length write are junk, only the low bits count
        word = {$urandom, $urandom};
        word[LEN_BITS-1:0] = signature_len;
        write_reg(REG_BASE_ADDRESS, region_base);
        write_reg(REG_PATTERN_LENGTH, word);
        for (int w = 0; w < PATTERN_WORDS; w++)
        begin
            for (int b = 0; b < 8; b++)
                word[b * 8 +: 8] = signature[w * 8 + b];
            write_reg(CFG_INDEX_BITS'(REG_PATTERN_0 + w), word);
        end
        write_reg(UNMAPPED_INDEX_LO, {$urandom, $urandom});
        write_reg(UNMAPPED_INDEX_HI, {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    task automatic fill_signature(input signature_fill_t fill);
        for (int j = 0; j < PATTERN_BYTES; j++)
        begin
            case (fill)
                FILL_ONES:     signature[j] = 8'hFF;
                FILL_ZEROS:    signature[j] = 8'h00;
                FILL_WILDCARD: signature[j] = WILDCARD;
                default:
                begin
                    if ($urandom_range(0, 99) < 20)
                        signature[j] = WILDCARD;
                    else
                        signature[j] = 8'($urandom);
                end
            endcase
        end
    endtask

    // hold the input idle until every region result is out, then let the pipe drain
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] data, input logic first_flag,
                             input logic last_flag);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= data;
        in_ch.first_byte <= first_flag;
        in_ch.last_byte  <= last_flag;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // background bytes lean on signature bytes to produce near misses
    function automatic logic [7:0] filler_byte();
        int plen;
        plen = int'(signature_len);
        if (plen >= 1 && plen <= MAX_PATTERN && $urandom_range(0, 99) < 30)
            return signature[$urandom_range(0, plen - 1)];
        return 8'($urandom);
    endfunction

    task automatic send_region(input int region_len, input bit plant,
                               input region_shape_t kind);
        logic [7:0] region_bytes[$];
        int         plen;
        int         at;
        logic       first_flag;
        logic       last_flag;
        plen = int'(signature_len);
        for (int i = 0; i < region_len; i++)
            region_bytes.push_back(filler_byte());
        if (plant && plen >= 1 && plen <= MAX_PATTERN && region_len >= plen)
        begin
            at = $urandom_range(0, region_len - plen);
            for (int j = 0; j < plen; j++)
                region_bytes[at + j] = (signature[j] == WILDCARD) ? 8'($urandom)
                                                                  : signature[j];
        end
        for (int i = 0; i < region_len; i++)
        begin
            first_flag = (i == 0);
            last_flag  = (i == region_len - 1);
            case (kind)
                REGION_NO_START: first_flag = 1'b0;
                REGION_NO_END:   last_flag  = 1'b0;
                REGION_SCRAMBLED:
                begin
                    first_flag = ($urandom_range(0, 9) == 0);
                    last_flag  = ($urandom_range(0, 9) == 0);
                end
                default: ;
            endcase
            send_byte(region_bytes[i], first_flag, last_flag);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = 8'h00;
        in_ch.first_byte = 1'b0;
        in_ch.last_byte  = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_BASE_ADDRESS;
        cfg_data         = '0;
        in_idle_pct      = IDLE_PCT;
        out_idle_pct     = IDLE_PCT;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes before any region start count as a region at offset zero
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        wait_idle();

        // 00 ? FF at the top of the address space, so the match address wraps
        region_base   = '1;
        signature_len = LEN_BITS'(3);
        fill_signature(FILL_ONES);
        signature[0] = 8'h00;
        signature[1] = WILDCARD;
        load_signature();
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        // after the result: neither more bytes nor a last byte answer again
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        // regions shorter than the pattern
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h3F, 1'b0, 1'b1);
        // match completes on the last byte
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'h99, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        wait_idle();

        // lengths above the pattern size never match
        region_base   = '0;
        signature_len = '1;
        fill_signature(FILL_WILDCARD);
        load_signature();
        send_byte(8'h3F, 1'b1, 1'b1);
        wait_idle();
        signature_len = LEN_BITS'(MAX_PATTERN + 1);
        load_signature();
        send_byte(8'hA5, 1'b1, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b1);
        wait_idle();

        // single wildcard byte matches the first byte of the region
        signature_len = LEN_BITS'(1);
        load_signature();
        send_byte(8'hA5, 1'b1, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b1);
        wait_idle();
        fill_signature(FILL_ZEROS);
        region_base = {$urandom, $urandom};
        load_signature();
        send_byte(8'h00, 1'b1, 1'b1);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            in_idle_pct   = IDLE_PCT;
            out_idle_pct  = IDLE_PCT;
            region_base   = {$urandom, $urandom};
            signature_len = LEN_BITS'($urandom_range(1, 12));
            if ($urandom_range(0, 9) == 0)
                signature_len = LEN_BITS'($urandom_range(13, MAX_PATTERN));
            fill_signature(FILL_RANDOM);
            case (phase)
                0:
                begin
                    signature_len = LEN_BITS'(MAX_PATTERN);
                    region_base   = '0;
                end
                1:
                begin
                    signature_len = '0;
                    region_base   = '1;
                end
                2: signature_len = '1;
                3: signature_len = LEN_BITS'(1);
                4:
                begin
                    signature_len = LEN_BITS'($urandom_range(2, 6));
                    fill_signature(FILL_ONES);
                end
                5:
                begin
                    signature_len = LEN_BITS'($urandom_range(2, 6));
                    fill_signature(FILL_ZEROS);
                end
                6, 7:
                begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
                8:
                begin
                    signature_len = LEN_BITS'(MAX_PATTERN);
                    fill_signature(FILL_WILDCARD);
                    region_base = '1;
                end
                default: ;
            endcase
            load_signature();
            sent = 0;
            while (sent < RANDOM_BYTES / RANDOM_PHASES)
            begin
                if (signature_len >= 1 && signature_len <= MAX_PATTERN)
                    span = $urandom_range(1, int'(signature_len) + 16);
                else
                    span = $urandom_range(1, 16);
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    shape = REGION_CLEAN;
                else if (roll < 85)
                    shape = REGION_NO_START;
                else if (roll < 93)
                    shape = REGION_NO_END;
                else
                    shape = REGION_SCRAMBLED;
                send_region(span, $urandom_range(0, 99) < 65, shape);
                sent += span;
            end
        end

        wait_idle();
        if (fail_count == 0 && pending_results == 0)
            $display("tb_wildcard_byte_pattern_scan_top OK");
        else
            $display("tb_wildcard_byte_pattern_scan_top NOT OK");
        $finish;
    end

endmodule
